### rtl/rpmc_pkg.sv
`default_nettype none

package rpmc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgValidWindow  = 3'd0;
  localparam logic [2:0] CfgOffBand      = 3'd1;
  localparam logic [2:0] CfgDefaultBand  = 3'd2;
  localparam logic [2:0] CfgSelectBand   = 3'd3;
  localparam logic [2:0] CfgArmThreshold = 3'd4;
  localparam logic [2:0] CfgCentreWindow = 3'd5;
  localparam logic [2:0] CfgMelodyCount  = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] RstValidWindow  = 32'd144180000;
  localparam logic [31:0] RstOffBand      = 32'd75367350;
  localparam logic [31:0] RstDefaultBand  = 32'd104859000;
  localparam logic [31:0] RstSelectBand   = 32'd137627450;
  localparam logic [15:0] RstArmThreshold = 16'd1700;
  localparam logic [31:0] RstCentreWindow = 32'd104859000;
  localparam logic [4:0]  RstMelodyCount  = 5'd4;

  // Buzzer mode codes.
  localparam logic [1:0] ModeOff    = 2'd0;
  localparam logic [1:0] ModeCustom = 2'd1;
  localparam logic [1:0] ModeError  = 2'd2;

  // The default melody.
  localparam logic [3:0] DefaultIndex = 4'd1;

  // Depth of the queue between classifier and executor.
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [31:0] valid_window;
    logic [31:0] off_band;
    logic [31:0] default_band;
    logic [31:0] select_band;
    logic [15:0] arm_threshold;
    logic [31:0] centre_window;
    logic [4:0]  count;        // effective melody count, already limited
  } cfg_t;

  // One classified item as the executor sees it.
  typedef struct packed {
    logic        in_valid;     // mode pulse inside the valid window
    logic        in_off;
    logic        in_default;
    logic        in_select;
    logic        choose_high;  // choose pulse above the arm threshold
    logic        in_centre;
    logic [3:0]  start_index;  // stored index, zero when out of range
    logic [15:0] choose_pulse;
  } item_t;

endpackage

`default_nettype wire

### rtl/rc_pulse_melody_mode_controller_core.sv
`default_nettype none

// RC pulse melody mode controller. Each transfer in carries one pair of RC pulse
// widths (mode and melody-select channel) and the melody index held in
// nonvolatile storage; each yields exactly one result transfer with the buzzer
// mode, a mode-issue flag, the selected melody index, a load flag and a
// storage-write request. Both sides behave like a queue: push/full in,
// empty/pop out. A classifier compares the pulses against the configured
// windows and bands as the item is pushed, a two-entry queue holds the
// classified items, and an executor applies them to the controller state and
// drives a one-entry result register. One item is accepted every cycle while
// full is low. A pushed item is written into the queue and then taken by the
// executor into the result register, from which it is popped; the executor
// updates its state as it takes each item. While the result register is full
// and not popped, the queue absorbs up to two further items before full rises.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i and
// must only change while the block is idle.
module rc_pulse_melody_mode_controller_core #(
  parameter int unsigned MAX_MELODIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] mode_pulse_i,
  input  wire logic [15:0] choose_pulse_i,
  input  wire logic [7:0]  stored_index_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       mode_o,
  output logic             mode_set_o,
  output logic [3:0]       melody_index_o,
  output logic             melody_load_o,
  output logic             store_write_o
);

  // The index is four bits wide, so the count never exceeds sixteen.
  localparam int unsigned CountCap = (MAX_MELODIES < 16) ? MAX_MELODIES : 16;
  localparam logic [4:0]  CountLimit = 5'(CountCap);

  logic [31:0] valid_window_q, off_band_q, default_band_q, select_band_q, centre_window_q;
  logic [15:0] arm_threshold_q;
  logic [4:0]  melody_count_q;

  rpmc_pkg::cfg_t  cfg;
  rpmc_pkg::item_t front_item, queue_item;
  logic            queue_full, queue_valid, back_take, push_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_window_q  <= rpmc_pkg::RstValidWindow;
      off_band_q      <= rpmc_pkg::RstOffBand;
      default_band_q  <= rpmc_pkg::RstDefaultBand;
      select_band_q   <= rpmc_pkg::RstSelectBand;
      arm_threshold_q <= rpmc_pkg::RstArmThreshold;
      centre_window_q <= rpmc_pkg::RstCentreWindow;
      melody_count_q  <= rpmc_pkg::RstMelodyCount;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpmc_pkg::CfgValidWindow:  valid_window_q  <= cfg_data_i;
        rpmc_pkg::CfgOffBand:      off_band_q      <= cfg_data_i;
        rpmc_pkg::CfgDefaultBand:  default_band_q  <= cfg_data_i;
        rpmc_pkg::CfgSelectBand:   select_band_q   <= cfg_data_i;
        rpmc_pkg::CfgArmThreshold: arm_threshold_q <= cfg_data_i[15:0];
        rpmc_pkg::CfgCentreWindow: centre_window_q <= cfg_data_i;
        rpmc_pkg::CfgMelodyCount:  melody_count_q  <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // Everything downstream sees the limited count.
  always_comb begin
    cfg.valid_window  = valid_window_q;
    cfg.off_band      = off_band_q;
    cfg.default_band  = default_band_q;
    cfg.select_band   = select_band_q;
    cfg.arm_threshold = arm_threshold_q;
    cfg.centre_window = centre_window_q;
    cfg.count         = (melody_count_q > CountLimit) ? CountLimit : melody_count_q;
  end

  assign full    = queue_full;
  assign push_ok = push && !queue_full;

  rpmc_front u_front (
    .mode_pulse_i   (mode_pulse_i),
    .choose_pulse_i (choose_pulse_i),
    .stored_index_i (stored_index_i),
    .cfg_i          (cfg),
    .item_o         (front_item)
  );

  rpmc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push_ok),
    .wr_item_i  (front_item),
    .full_o     (queue_full),
    .rd_en_i    (back_take),
    .rd_item_o  (queue_item),
    .rd_valid_o (queue_valid)
  );

  rpmc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .item_take_o    (back_take),
    .empty_o        (empty),
    .pop_i          (pop),
    .mode_o         (mode_o),
    .mode_set_o     (mode_set_o),
    .melody_index_o (melody_index_o),
    .melody_load_o  (melody_load_o),
    .store_write_o  (store_write_o)
  );

endmodule

`default_nettype wire

### rtl/rpmc_front.sv
`default_nettype none

module rpmc_front (
  input  wire logic [15:0]   mode_pulse_i,
  input  wire logic [15:0]   choose_pulse_i,
  input  wire logic [7:0]    stored_index_i,
  input  wire rpmc_pkg::cfg_t cfg_i,
  output rpmc_pkg::item_t    item_o
);

  function automatic logic in_open(input logic [15:0] v, input logic [31:0] r);
    in_open = (v > r[15:0]) && (v < r[31:16]);
  endfunction

  function automatic logic in_closed(input logic [15:0] v, input logic [31:0] r);
    in_closed = (v >= r[15:0]) && (v <= r[31:16]);
  endfunction

  always_comb begin
    item_o.in_valid     = in_closed(mode_pulse_i, cfg_i.valid_window);
    item_o.in_off       = in_open(mode_pulse_i, cfg_i.off_band);
    item_o.in_default   = in_open(mode_pulse_i, cfg_i.default_band);
    item_o.in_select    = in_open(mode_pulse_i, cfg_i.select_band);
    item_o.choose_high  = choose_pulse_i > cfg_i.arm_threshold;
    item_o.in_centre    = in_closed(choose_pulse_i, cfg_i.centre_window);
    // An index below the count is below 16, so its low nibble is the whole value.
    if ({3'b000, stored_index_i[7:0]} >= {6'd0, cfg_i.count}) begin
      item_o.start_index = 4'd0;
    end else begin
      item_o.start_index = stored_index_i[3:0];
    end
    item_o.choose_pulse = choose_pulse_i;
  end

endmodule

`default_nettype wire

### rtl/rpmc_queue.sv
`default_nettype none

module rpmc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire rpmc_pkg::item_t wr_item_i,
  output logic                 full_o,
  input  wire logic            rd_en_i,
  output rpmc_pkg::item_t      rd_item_o,
  output logic                 rd_valid_o
);

  localparam int unsigned PtrW = (rpmc_pkg::QDepth > 1) ? $clog2(rpmc_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(rpmc_pkg::QDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(rpmc_pkg::QDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rpmc_pkg::QDepth - 1);

  rpmc_pkg::item_t mem_q [rpmc_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == Depth);
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rpmc_back.sv
`default_nettype none

module rpmc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rpmc_pkg::cfg_t  cfg_i,
  input  wire logic            item_valid_i,
  input  wire rpmc_pkg::item_t item_i,
  output logic                 item_take_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output logic [1:0]           mode_o,
  output logic                 mode_set_o,
  output logic [3:0]           melody_index_o,
  output logic                 melody_load_o,
  output logic                 store_write_o
);

  logic [1:0]  mode_now_q, mode_now_d, mode_before_q, mode_before_d;
  logic        default_q, default_d, entered_q, entered_d, armed_q, armed_d;
  logic [15:0] last_cp_q, last_cp_d;
  logic [3:0]  index_q, index_d;
  logic        set_d, load_d, store_d;
  logic [4:0]  next_index;

  logic        out_valid_q;
  logic [1:0]  out_mode_q;
  logic        out_set_q, out_load_q, out_store_q;
  logic [3:0]  out_index_q;

  // The result register frees up when it is empty or being popped.
  assign item_take_o = item_valid_i && (!out_valid_q || pop_i);

  always_comb begin
    mode_now_d    = mode_now_q;
    mode_before_d = mode_before_q;
    default_d     = default_q;
    entered_d     = entered_q;
    armed_d       = armed_q;
    last_cp_d     = last_cp_q;
    index_d       = index_q;
    set_d         = 1'b0;
    load_d        = 1'b0;
    store_d       = 1'b0;
    next_index    = '0;
    if (!item_i.in_valid) begin
      // Error leaves everything else as it was.
      mode_now_d = rpmc_pkg::ModeError;
      set_d      = 1'b1;
    end else begin
      if (item_i.in_off) begin
        mode_now_d = rpmc_pkg::ModeOff;
        set_d      = 1'b1;
      end else if (item_i.in_default) begin
        if (!default_q) begin
          index_d    = rpmc_pkg::DefaultIndex;
          load_d     = 1'b1;
          mode_now_d = rpmc_pkg::ModeCustom;
          default_d  = 1'b1;
        end
        entered_d = 1'b0;
      end else if (item_i.in_select) begin
        default_d = 1'b0;
        if (!entered_q) begin
          entered_d = 1'b1;
          index_d   = item_i.start_index;
          load_d    = 1'b1;
          set_d     = 1'b1;
        end
        if (item_i.choose_high && (last_cp_q <= cfg_i.arm_threshold)) begin
          armed_d = 1'b1;
        end
        if (item_i.in_centre && armed_d) begin
          armed_d    = 1'b0;
          next_index = {1'b0, index_d} + 5'd1;
          index_d    = (next_index >= cfg_i.count) ? 4'd0 : next_index[3:0];
          store_d    = 1'b1;
          load_d     = 1'b1;
          set_d      = 1'b1;
        end
        last_cp_d  = item_i.choose_pulse;
        mode_now_d = rpmc_pkg::ModeCustom;
      end else if (default_q || entered_q) begin
        default_d  = 1'b0;
        entered_d  = 1'b0;
        mode_now_d = rpmc_pkg::ModeOff;
      end
      if (mode_now_d != mode_before_q) begin
        set_d         = 1'b1;
        mode_before_d = mode_now_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_now_q    <= rpmc_pkg::ModeOff;
      mode_before_q <= rpmc_pkg::ModeOff;
      default_q     <= 1'b0;
      entered_q     <= 1'b0;
      armed_q       <= 1'b0;
      last_cp_q     <= '0;
      index_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (item_take_o) begin
        mode_now_q    <= mode_now_d;
        mode_before_q <= mode_before_d;
        default_q     <= default_d;
        entered_q     <= entered_d;
        armed_q       <= armed_d;
        last_cp_q     <= last_cp_d;
        index_q       <= index_d;
        out_valid_q   <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      out_mode_q  <= mode_now_d;
      out_set_q   <= set_d;
      out_index_q <= index_d;
      out_load_q  <= load_d;
      out_store_q <= store_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign mode_o         = out_mode_q;
  assign mode_set_o     = out_set_q;
  assign melody_index_o = out_index_q;
  assign melody_load_o  = out_load_q;
  assign store_write_o  = out_store_q;

  // A storage request always comes with a fresh load and a mode issue.
  a_store_implies_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_store_q) |-> (out_load_q && out_set_q))
    else $error("store request without load and mode issue");

  // The mode register never holds the unused fourth code.
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_now_q != 2'd3)
    else $error("mode register holds an unused code");

  // An advance leaves an index below the count, or zero.
  a_store_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && store_d) |=> (index_q == 4'd0 || {1'b0, index_q} < $past(cfg_i.count)))
    else $error("advanced index out of range");

  // Without a transfer in, the executor state stays put.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_take_o |=> ($stable(index_q) && $stable(mode_now_q) && $stable(armed_q)))
    else $error("executor state changed without a transfer");

endmodule

`default_nettype wire

### verif/rc_pulse_melody_mode_controller_core_test.sv
module rc_pulse_melody_mode_controller_core_test;

  // Same melody limit as the instance below.
  localparam int unsigned MaxMelodies = 16;
  // Cycles with no input transfer, result transfer or register write before the run is abandoned.
  localparam int unsigned QuietLimit = 2000;

  // One RC frame as the sender pushes it.
  typedef struct packed {
    logic [15:0] mode_pulse;
    logic [15:0] choose_pulse;
    logic [7:0]  stored_index;
  } pulse_pair_t;

  // One result as the block presents it on its output ports.
  typedef struct packed {
    logic [1:0] mode;
    logic       mode_set;
    logic [3:0] melody_index;
    logic       melody_load;
    logic       store_write;
  } buzzer_result_t;

  // Where the random generator places the mode pulse. The choice is sticky, so
  // most of the run consists of longer stays in one band, selection above all.
  typedef enum int {
    ClassOff,
    ClassDefault,
    ClassSelect,
    ClassValid,
    ClassAny,
    ClassExtreme
  } pulse_class_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = rpmc_pkg::CfgValidWindow;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] mode_pulse_i = '0;
  logic [15:0] choose_pulse_i = '0;
  logic [7:0]  stored_index_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  mode_o;
  logic        mode_set_o;
  logic [3:0]  melody_index_o;
  logic        melody_load_o;
  logic        store_write_o;

  rc_pulse_melody_mode_controller_core #(
    .MAX_MELODIES(MaxMelodies)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .mode_pulse_i  (mode_pulse_i),
    .choose_pulse_i(choose_pulse_i),
    .stored_index_i(stored_index_i),
    .empty         (empty),
    .pop           (pop),
    .mode_o        (mode_o),
    .mode_set_o    (mode_set_o),
    .melody_index_o(melody_index_o),
    .melody_load_o (melody_load_o),
    .store_write_o (store_write_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Frames waiting to be pushed, and the results the accepted frames must produce,
  // oldest first.
  pulse_pair_t    pulse_pairs_to_send[$];
  buzzer_result_t buzzer_results_due[$];

  // Testbench copy of the configuration registers, kept equal to what was written.
  logic [31:0] cfg_valid = rpmc_pkg::RstValidWindow;
  logic [31:0] cfg_off = rpmc_pkg::RstOffBand;
  logic [31:0] cfg_default = rpmc_pkg::RstDefaultBand;
  logic [31:0] cfg_select = rpmc_pkg::RstSelectBand;
  logic [15:0] cfg_arm = rpmc_pkg::RstArmThreshold;
  logic [31:0] cfg_centre = rpmc_pkg::RstCentreWindow;
  logic [4:0]  cfg_count = rpmc_pkg::RstMelodyCount;

  // Controller state as the block should hold it, starting from reset.
  logic [1:0]  mode_now = rpmc_pkg::ModeOff;
  logic [1:0]  mode_before = rpmc_pkg::ModeOff;
  logic        default_active = 1'b0;
  logic        selection_entered = 1'b0;
  logic        advance_armed = 1'b0;
  logic [15:0] last_choose = '0;
  logic [3:0]  melody_now = '0;

  pulse_class_e   pulse_class = ClassSelect;
  pulse_pair_t    pair_on_pins;
  buzzer_result_t got;
  buzzer_result_t want;

  int unsigned pairs_queued = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_checked = 0;
  int unsigned advances_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned settings_written = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned quiet_cycles = 0;

  // Band helpers: each register packs the lower bound in bits 15:0 and the upper
  // bound in bits 31:16.
  function automatic logic in_open(logic [15:0] v, logic [31:0] r);
    return v > r[15:0] && v < r[31:16];
  endfunction

  function automatic logic in_closed(logic [15:0] v, logic [31:0] r);
    return v >= r[15:0] && v <= r[31:16];
  endfunction

  // Applies one frame to the state copy and returns the result it must produce.
  function automatic buzzer_result_t step_buzzer_model(pulse_pair_t p);
    buzzer_result_t r;
    int unsigned cnt;
    int unsigned nxt;
    logic issued;
    logic loaded;
    logic stored;
    cnt = (cfg_count > MaxMelodies) ? MaxMelodies : cfg_count;
    if (cnt > 16) cnt = 16;
    issued = 1'b0;
    loaded = 1'b0;
    stored = 1'b0;
    if (!in_closed(p.mode_pulse, cfg_valid)) begin
      // Error mode leaves every other piece of state alone, mode_before included.
      mode_now = rpmc_pkg::ModeError;
      issued = 1'b1;
    end else begin
      if (in_open(p.mode_pulse, cfg_off)) begin
        mode_now = rpmc_pkg::ModeOff;
        issued = 1'b1;
      end else if (in_open(p.mode_pulse, cfg_default)) begin
        if (!default_active) begin
          melody_now = rpmc_pkg::DefaultIndex;
          loaded = 1'b1;
          mode_now = rpmc_pkg::ModeCustom;
          default_active = 1'b1;
        end
        selection_entered = 1'b0;
      end else if (in_open(p.mode_pulse, cfg_select)) begin
        default_active = 1'b0;
        if (!selection_entered) begin
          selection_entered = 1'b1;
          melody_now = (p.stored_index >= cnt) ? 4'd0 : p.stored_index[3:0];
          loaded = 1'b1;
          issued = 1'b1;
        end
        if (p.choose_pulse > cfg_arm && last_choose <= cfg_arm) advance_armed = 1'b1;
        if (in_closed(p.choose_pulse, cfg_centre) && advance_armed) begin
          // A stale index at or above a shrunk count wraps to zero as well.
          nxt = int'(melody_now) + 1;
          advance_armed = 1'b0;
          melody_now = (nxt >= cnt) ? 4'd0 : nxt[3:0];
          stored = 1'b1;
          loaded = 1'b1;
          issued = 1'b1;
        end
        last_choose = p.choose_pulse;
        mode_now = rpmc_pkg::ModeCustom;
      end else if (default_active || selection_entered) begin
        default_active = 1'b0;
        selection_entered = 1'b0;
        mode_now = rpmc_pkg::ModeOff;
      end
      if (mode_now != mode_before) begin
        issued = 1'b1;
        mode_before = mode_now;
      end
    end
    r.mode = mode_now;
    r.mode_set = issued;
    r.melody_index = melody_now;
    r.melody_load = loaded;
    r.store_write = stored;
    return r;
  endfunction

  // Random value strictly inside a band, or any value when the band is empty.
  function automatic logic [15:0] pick_open(logic [31:0] r);
    if (r[31:16] > r[15:0] + 1) return 16'($urandom_range(r[31:16] - 1, r[15:0] + 1));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_closed(logic [31:0] r);
    if (r[31:16] >= r[15:0]) return 16'($urandom_range(r[31:16], r[15:0]));
    return 16'($urandom);
  endfunction

  function automatic pulse_pair_t next_random_pair();
    pulse_pair_t p;
    int unsigned roll;
    if ($urandom_range(5, 0) == 0) begin
      roll = $urandom_range(99, 0);
      if (roll < 40) pulse_class = ClassSelect;
      else if (roll < 55) pulse_class = ClassDefault;
      else if (roll < 70) pulse_class = ClassOff;
      else if (roll < 85) pulse_class = ClassValid;
      else if (roll < 95) pulse_class = ClassAny;
      else pulse_class = ClassExtreme;
    end
    case (pulse_class)
      ClassOff:     p.mode_pulse = pick_open(cfg_off);
      ClassDefault: p.mode_pulse = pick_open(cfg_default);
      ClassSelect:  p.mode_pulse = pick_open(cfg_select);
      ClassValid:   p.mode_pulse = pick_closed(cfg_valid);
      ClassAny:     p.mode_pulse = 16'($urandom);
      default:      p.mode_pulse = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    endcase
    // The select channel mostly swings between above the threshold and the
    // centre window, which is what arms and then executes an advance.
    roll = $urandom_range(99, 0);
    if (roll < 35 && cfg_arm != 16'hFFFF)
      p.choose_pulse = 16'($urandom_range(16'hFFFF, cfg_arm + 1));
    else if (roll < 70) p.choose_pulse = pick_closed(cfg_centre);
    else if (roll < 85) p.choose_pulse = 16'($urandom_range(cfg_arm, 0));
    else p.choose_pulse = 16'($urandom);
    if ($urandom_range(1, 0) != 0) p.stored_index = 8'($urandom_range(cfg_count + 2, 0));
    else p.stored_index = 8'($urandom);
    return p;
  endfunction

  function automatic void queue_pair(logic [15:0] mp, logic [15:0] cp, logic [7:0] si);
    pulse_pair_t p;
    p.mode_pulse = mp;
    p.choose_pulse = cp;
    p.stored_index = si;
    pulse_pairs_to_send.push_back(p);
    pairs_queued++;
  endfunction

  function automatic void queue_random_pairs(int unsigned n);
    repeat (n) begin
      pulse_pairs_to_send.push_back(next_random_pair());
      pairs_queued++;
    end
  endfunction

  // A quarter of the phases run without any idling at all.
  function automatic void pick_idling();
    if ($urandom_range(3, 0) == 0) begin
      send_idle_pct = 0;
      take_idle_pct = 0;
    end else begin
      send_idle_pct = $urandom_range(50, 10);
      take_idle_pct = $urandom_range(50, 10);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t, result %0d: %s", $time, results_checked, what);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      rpmc_pkg::CfgValidWindow:  cfg_valid = value;
      rpmc_pkg::CfgOffBand:      cfg_off = value;
      rpmc_pkg::CfgDefaultBand:  cfg_default = value;
      rpmc_pkg::CfgSelectBand:   cfg_select = value;
      rpmc_pkg::CfgArmThreshold: cfg_arm = value[15:0];
      rpmc_pkg::CfgCentreWindow: cfg_centre = value;
      rpmc_pkg::CfgMelodyCount:  cfg_count = value[4:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [31:0] valid_r, input logic [31:0] off_r,
                                input logic [31:0] default_r, input logic [31:0] select_r,
                                input logic [31:0] arm_r, input logic [31:0] centre_r,
                                input logic [31:0] count_r);
    write_reg(rpmc_pkg::CfgValidWindow, valid_r);
    write_reg(rpmc_pkg::CfgOffBand, off_r);
    write_reg(rpmc_pkg::CfgDefaultBand, default_r);
    write_reg(rpmc_pkg::CfgSelectBand, select_r);
    write_reg(rpmc_pkg::CfgArmThreshold, arm_r);
    write_reg(rpmc_pkg::CfgCentreWindow, centre_r);
    write_reg(rpmc_pkg::CfgMelodyCount, count_r);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  // Mostly bands laid out like a real transmitter setup with jitter, sometimes
  // fully random registers so that bands overlap or come out empty.
  task automatic write_random_regs();
    logic [15:0] valid_lo;
    logic [15:0] valid_hi;
    logic [15:0] off_lo;
    logic [15:0] default_lo;
    logic [15:0] select_lo;
    logic [15:0] centre_lo;
    if ($urandom_range(3, 0) == 0) begin
      write_all_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(16, 2));
    end else begin
      valid_lo = 16'($urandom_range(900, 0));
      valid_hi = 16'($urandom_range(65535, 2100));
      off_lo = 16'($urandom_range(1000, 800));
      default_lo = 16'($urandom_range(1450, 1300));
      select_lo = 16'($urandom_range(1900, 1700));
      centre_lo = 16'($urandom_range(1500, 1300));
      write_all_regs({valid_hi, valid_lo},
                     {off_lo + 16'($urandom_range(300, 2)), off_lo},
                     {default_lo + 16'($urandom_range(250, 2)), default_lo},
                     {select_lo + 16'($urandom_range(300, 2)), select_lo},
                     $urandom_range(2000, 1400),
                     {centre_lo + 16'($urandom_range(300, 0)), centre_lo},
                     $urandom_range(16, 2));
    end
  endtask

  // The sender holds off until every queued frame went in and every result came back.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pairs_sent != pairs_queued || buzzer_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Driver: on an input transfer the prediction is made from the frame that was
  // on the pins, then the next frame or an idle cycle is set up. A frame that
  // met full stays on the pins untouched.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        buzzer_results_due.push_back(step_buzzer_model(pair_on_pins));
        pairs_sent++;
      end
      if (!(push && full)) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pulse_pairs_to_send.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(99, 0) < send_idle_pct) begin
          send_gap = $urandom_range(3, 0);
          push <= 1'b0;
        end else if (pulse_pairs_to_send.size() != 0) begin
          pair_on_pins = pulse_pairs_to_send.pop_front();
          mode_pulse_i <= pair_on_pins.mode_pulse;
          choose_pulse_i <= pair_on_pins.choose_pulse;
          stored_index_i <= pair_on_pins.stored_index;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction,
  // field by field, and pop is stalled in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        got = {mode_o, mode_set_o, melody_index_o, melody_load_o, store_write_o};
        if (buzzer_results_due.size() == 0) begin
          report_mismatch("result transfer with no frame outstanding");
        end else begin
          want = buzzer_results_due.pop_front();
          if (want.store_write) advances_seen++;
          if (want.mode == rpmc_pkg::ModeError) errors_seen++;
          if (got.mode !== want.mode)
            report_mismatch($sformatf("mode %0d, expected %0d", got.mode, want.mode));
          if (got.mode_set !== want.mode_set)
            report_mismatch($sformatf("mode_set %0b, expected %0b", got.mode_set,
                                      want.mode_set));
          if (got.melody_index !== want.melody_index)
            report_mismatch($sformatf("melody_index %0d, expected %0d", got.melody_index,
                                      want.melody_index));
          if (got.melody_load !== want.melody_load)
            report_mismatch($sformatf("melody_load %0b, expected %0b", got.melody_load,
                                      want.melody_load));
          if (got.store_write !== want.store_write)
            report_mismatch($sformatf("store_write %0b, expected %0b", got.store_write,
                                      want.store_write));
        end
        results_checked++;
      end
      if (take_gap != 0) begin
        take_gap--;
        pop <= 1'b0;
      end else if (take_idle_pct != 0 && $urandom_range(99, 0) < take_idle_pct) begin
        take_gap = $urandom_range(3, 0);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("Timeout: no transfer for %0d cycles", QuietLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset configuration: valid window 800..2200, off
    // band 950..1150, default band 1400..1600, selection band 1850..2100, arm
    // threshold 1700, centre window 1400..1600, four melodies.
    pick_idling();
    queue_pair(16'd0, 16'd0, 8'd0);               // error at the bottom extreme
    queue_pair(16'hFFFF, 16'hFFFF, 8'hFF);        // error at the top extreme
    queue_pair(16'd799, 16'd1500, 8'd0);          // just below the valid window
    queue_pair(16'd800, 16'd1000, 8'd0);          // valid edge, no band: stays in error mode
    queue_pair(16'd1000, 16'd1000, 8'd0);         // off
    queue_pair(16'd950, 16'd1000, 8'd0);          // off band bounds are exclusive
    queue_pair(16'd1150, 16'd1000, 8'd0);
    queue_pair(16'd1500, 16'd1000, 8'd0);         // default melody loads once
    queue_pair(16'd1500, 16'd1000, 8'd0);
    queue_pair(16'd1000, 16'd1000, 8'd0);         // off keeps the default flag
    queue_pair(16'd1500, 16'd1000, 8'd0);         // so no second load here
    queue_pair(16'd1300, 16'd1000, 8'd0);         // stop clears both flags
    queue_pair(16'd2000, 16'd1000, 8'd200);       // selection with out-of-range index
    queue_pair(16'd2000, 16'd1900, 8'd0);         // arm
    queue_pair(16'd2000, 16'd1500, 8'd0);         // advance to 1
    queue_pair(16'd2000, 16'd1900, 8'd0);
    queue_pair(16'd2000, 16'd1500, 8'd0);         // advance to 2
    queue_pair(16'd2000, 16'hFFFF, 8'd0);
    queue_pair(16'd2000, 16'd1400, 8'd0);         // centre lower edge, advance to 3
    queue_pair(16'd2000, 16'd1701, 8'd0);
    queue_pair(16'd2000, 16'd1600, 8'd0);         // centre upper edge, wrap to 0
    queue_pair(16'd2000, 16'd1700, 8'd0);         // at the threshold does not arm
    queue_pair(16'd2000, 16'd1500, 8'd0);
    queue_pair(16'd2201, 16'd0, 8'd0);            // error while in selection
    queue_pair(16'd2100, 16'd1500, 8'd3);         // selection upper bound is exclusive
    queue_pair(16'd2099, 16'd0, 8'd3);            // re-enter with a valid stored index
    queue_pair(16'd2200, 16'd0, 8'd0);
    wait_drained();

    queue_random_pairs(250);
    wait_drained();

    // Stale index: reach index 14 with sixteen melodies, then shrink the count
    // while still in selection and advance once more.
    write_all_regs(rpmc_pkg::RstValidWindow, rpmc_pkg::RstOffBand,
                   rpmc_pkg::RstDefaultBand, rpmc_pkg::RstSelectBand,
                   rpmc_pkg::RstArmThreshold, rpmc_pkg::RstCentreWindow, 32'd16);
    pick_idling();
    queue_pair(16'd1300, 16'd1000, 8'd0);
    queue_pair(16'd2000, 16'd1000, 8'd12);
    queue_pair(16'd2000, 16'd1900, 8'd0);
    queue_pair(16'd2000, 16'd1500, 8'd0);
    queue_pair(16'd2000, 16'd1900, 8'd0);
    queue_pair(16'd2000, 16'd1500, 8'd0);
    wait_drained();
    write_all_regs(rpmc_pkg::RstValidWindow, rpmc_pkg::RstOffBand,
                   rpmc_pkg::RstDefaultBand, rpmc_pkg::RstSelectBand,
                   rpmc_pkg::RstArmThreshold, rpmc_pkg::RstCentreWindow, 32'd4);
    queue_pair(16'd2000, 16'd1900, 8'd0);
    queue_pair(16'd2000, 16'd1500, 8'd0);
    wait_drained();

    // Oversized count limits to sixteen; counts of zero and one always give 0.
    write_all_regs(rpmc_pkg::RstValidWindow, rpmc_pkg::RstOffBand,
                   rpmc_pkg::RstDefaultBand, rpmc_pkg::RstSelectBand,
                   rpmc_pkg::RstArmThreshold, rpmc_pkg::RstCentreWindow, 32'd31);
    queue_pair(16'd1300, 16'd1000, 8'd0);
    queue_pair(16'd2000, 16'd1000, 8'd15);
    queue_pair(16'd2000, 16'd1900, 8'd0);
    queue_pair(16'd2000, 16'd1500, 8'd0);
    wait_drained();
    for (int c = 0; c < 2; c++) begin
      write_all_regs(rpmc_pkg::RstValidWindow, rpmc_pkg::RstOffBand,
                     rpmc_pkg::RstDefaultBand, rpmc_pkg::RstSelectBand,
                     rpmc_pkg::RstArmThreshold, rpmc_pkg::RstCentreWindow, 32'(c));
      queue_pair(16'd1300, 16'd1000, 8'd5);
      queue_pair(16'd2000, 16'd1000, 8'd5);
      queue_pair(16'd2000, 16'd1900, 8'd0);
      queue_pair(16'd2000, 16'd1500, 8'd0);
      wait_drained();
    end

    // Register extremes: everything valid with the lowest threshold and a count of two,
    // nothing valid, a threshold that can never be crossed, and overlapping bands
    // where the default band must win over selection.
    write_all_regs(32'hFFFF_0000, rpmc_pkg::RstOffBand, rpmc_pkg::RstDefaultBand,
                   rpmc_pkg::RstSelectBand, 32'd0, 32'hFFFF_0000, 32'd2);
    pick_idling();
    queue_random_pairs(90);
    wait_drained();
    write_all_regs(32'h0000_FFFF, rpmc_pkg::RstOffBand, rpmc_pkg::RstDefaultBand,
                   rpmc_pkg::RstSelectBand, 32'd0, 32'hFFFF_0000, 32'd2);
    queue_random_pairs(30);
    wait_drained();
    write_all_regs(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000,
                   32'h0000_FFFF, 32'h0000_0000, 32'd16);
    pick_idling();
    queue_random_pairs(60);
    wait_drained();
    write_all_regs(rpmc_pkg::RstValidWindow, 32'h0000_0000, rpmc_pkg::RstSelectBand,
                   rpmc_pkg::RstSelectBand, rpmc_pkg::RstArmThreshold,
                   rpmc_pkg::RstCentreWindow, 32'd16);
    queue_random_pairs(60);
    wait_drained();

    repeat (8) begin
      write_random_regs();
      pick_idling();
      queue_random_pairs(100);
      wait_drained();
    end

    // Last stretch: reset configuration again, both sides at full rate.
    write_all_regs(rpmc_pkg::RstValidWindow, rpmc_pkg::RstOffBand,
                   rpmc_pkg::RstDefaultBand, rpmc_pkg::RstSelectBand,
                   rpmc_pkg::RstArmThreshold, rpmc_pkg::RstCentreWindow,
                   rpmc_pkg::RstMelodyCount);
    send_idle_pct = 0;
    take_idle_pct = 0;
    queue_random_pairs(120);
    wait_drained();
    // A late or duplicated result would show up before the run ends.
    repeat (6) @(posedge clk_i);

    $display("Run covered %0d frames under %0d register settings, %0d results checked.",
             pairs_sent, settings_written, results_checked);
    $display("Among them %0d melody advances with a storage write and %0d error results.",
             advances_seen, errors_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rpmc_pkg.sv
rtl/rpmc_front.sv
rtl/rpmc_queue.sv
rtl/rpmc_back.sv
rtl/rc_pulse_melody_mode_controller_core.sv
verif/rc_pulse_melody_mode_controller_core_test.sv
